### rtl/radix_digit_converter_defines.svh
// ----------------------------------------------------------------------------
// Radix digit converter assertion macros
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_CONVERTER_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_DEFINES_SVH

// Same-cycle implication checked at every rising edge outside of reset.
`define RDC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked at every rising edge outside of reset.
`define RDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rdc_pkg.sv
// ----------------------------------------------------------------------------
// Radix digit converter package
// Word types, status and command codes, and the reciprocal table.
// ----------------------------------------------------------------------------
package rdc_pkg;

	// Digit stack sizing.
	localparam int MAX_DIGITS = 32;
	localparam int STACK_AW   = $clog2(MAX_DIGITS);
	localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

	// Result status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_BADBASE = 2'd2;

	// Command kinds passed from the front to the back.
	localparam logic [1:0] KIND_DIGITS  = 2'd0;
	localparam logic [1:0] KIND_ZERO    = 2'd1;
	localparam logic [1:0] KIND_EMPTY   = 2'd2;
	localparam logic [1:0] KIND_BADBASE = 2'd3;

	// Character constants.
	localparam logic [6:0] CHAR_ZERO   = 7'h30;
	localparam logic [6:0] CHAR_LETTER = 7'h41;
	localparam logic [5:0] DEC_LIMIT   = 6'd10;

	// Accepted radix range.
	localparam logic [5:0] RADIX_MIN = 6'd2;
	localparam logic [5:0] RADIX_MAX = 6'd36;

	// Reciprocals floor(2^32 / b); entries for zero and one are never used.
	localparam logic [63:0] POW32 = 64'h1_0000_0000;
	localparam logic [31:0] RECIP_TABLE [37] = '{
		32'd0, 32'd0,
		32'(POW32 / 2),  32'(POW32 / 3),  32'(POW32 / 4),  32'(POW32 / 5),
		32'(POW32 / 6),  32'(POW32 / 7),  32'(POW32 / 8),  32'(POW32 / 9),
		32'(POW32 / 10), 32'(POW32 / 11), 32'(POW32 / 12), 32'(POW32 / 13),
		32'(POW32 / 14), 32'(POW32 / 15), 32'(POW32 / 16), 32'(POW32 / 17),
		32'(POW32 / 18), 32'(POW32 / 19), 32'(POW32 / 20), 32'(POW32 / 21),
		32'(POW32 / 22), 32'(POW32 / 23), 32'(POW32 / 24), 32'(POW32 / 25),
		32'(POW32 / 26), 32'(POW32 / 27), 32'(POW32 / 28), 32'(POW32 / 29),
		32'(POW32 / 30), 32'(POW32 / 31), 32'(POW32 / 32), 32'(POW32 / 33),
		32'(POW32 / 34), 32'(POW32 / 35), 32'(POW32 / 36)
	};

	// Input word.
	typedef struct packed {
		logic signed [31:0] number;
		logic        [5:0]  radix;
	} item_t;

	// Output word.
	typedef struct packed {
		logic [6:0] digit_char;
		logic [1:0] status;
		logic       last;
	} result_t;

	// Classified command held in the queue between front and back.
	typedef struct packed {
		logic [1:0]  kind;
		logic [30:0] value;
		logic [5:0]  radix;
		logic [31:0] recip;
	} cmd_t;

	// Digit value to its ASCII character.
	function automatic logic [6:0] to_ascii(input logic [5:0] v);
		logic [6:0] ch;
		if (v < DEC_LIMIT) begin
			ch = CHAR_ZERO + {1'b0, v};
		end else begin
			ch = CHAR_LETTER + {1'b0, v - DEC_LIMIT};
		end
		return ch;
	endfunction

endpackage

### rtl/radix_digit_converter.sv
// ----------------------------------------------------------------------------
// Radix digit converter
// Converts a signed 32-bit number to ASCII digits in a base from 2 to 36.
// ----------------------------------------------------------------------------
// Each accepted word yields one or more output words, most significant digit
// first, with last set on the final one. Zero gives the single character '0',
// a negative number gives one word with the empty status and a positive number
// in a base outside 2..36 gives one word with the bad base status. A number of
// n digits, with n at most 31, passes the divide loop (a reciprocal multiply,
// then the remainder correction) once per digit, and then pops the stack, whose
// memory has a registered read, through a read and an emit step per digit. A
// two-entry command queue lets new words be taken while the back is still busy.
`include "radix_digit_converter_defines.svh"

module radix_digit_converter (
	input  logic             clk,
	input  logic             arst_n,
	input  rdc_pkg::item_t   item,
	input  logic             item_valid,
	output logic             item_ready,
	output rdc_pkg::result_t result,
	output logic             result_valid,
	input  logic             result_ready
);

	import rdc_pkg::*;

	logic queue_push;
	cmd_t queue_in;
	cmd_t queue_head;
	logic queue_pop;
	logic queue_full;
	logic queue_empty;

	// Classifying front.
	rdc_front u_front (
		.item      (item),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.queue_full(queue_full),
		.push      (queue_push),
		.push_cmd  (queue_in)
	);

	// Command queue between front and back.
	rdc_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (queue_push),
		.push_cmd(queue_in),
		.pop     (queue_pop),
		.head    (queue_head),
		.full    (queue_full),
		.empty   (queue_empty)
	);

	// Divide and emit back.
	rdc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (queue_head),
		.queue_empty (queue_empty),
		.pop         (queue_pop),
		.result      (result),
		.result_valid(result_valid),
		.result_ready(result_ready)
	);

	// Error words are always single and carry no character.
	`RDC_ASSERT_IMPL(a_error_single, result_valid && result.status != ST_OK, result.last && result.digit_char == 7'd0, "error word must be last and carry no character")

	// Digit words carry a character from '0'..'9' or 'A'..'Z'.
	`RDC_ASSERT_IMPL(a_digit_range, result_valid && result.status == ST_OK, (result.digit_char >= 7'h30 && result.digit_char <= 7'h39) || (result.digit_char >= 7'h41 && result.digit_char <= 7'h5A), "digit character out of range")

	// The queue never pops while empty and never takes a word while full.
	`RDC_ASSERT_IMPL(a_queue_guard, 1'b1, !(queue_pop && queue_empty) && !(queue_push && queue_full), "queue overrun or underrun")

	// Once a final word is taken while the queue is empty, the back cannot output again in the next cycle.
	`RDC_ASSERT_NEXT(a_last_gap, result_valid && result_ready && result.last && queue_empty, !result_valid, "output word without a queued command")

endmodule

### rtl/rdc_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module rdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/rdc_cmd_queue.sv
// ----------------------------------------------------------------------------
// Radix digit converter command queue
// Two-entry queue that decouples the classifying front from the back.
// ----------------------------------------------------------------------------
module rdc_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rdc_pkg::cmd_t push_cmd,
	input  logic          pop,
	output rdc_pkg::cmd_t head,
	output logic          full,
	output logic          empty
);

	import rdc_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	assign head  = entry_q[rd_ptr_q];
	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);

endmodule

### rtl/rdc_front.sv
// ----------------------------------------------------------------------------
// Radix digit converter front
// Accepts input words, sorts out the special cases and looks up the
// reciprocal of the radix for the back.
// ----------------------------------------------------------------------------
module rdc_front (
	input  rdc_pkg::item_t item,
	input  logic           item_valid,
	output logic           item_ready,
	input  logic           queue_full,
	output logic           push,
	output rdc_pkg::cmd_t  push_cmd
);

	import rdc_pkg::*;

	logic       radix_ok;
	logic [5:0] table_idx;

	// A word is taken whenever the queue has room.
	assign item_ready = !queue_full;
	assign push       = item_valid && !queue_full;

	// Classification and reciprocal lookup.
	always_comb begin
		radix_ok  = item.radix inside {[RADIX_MIN:RADIX_MAX]};
		table_idx = radix_ok ? item.radix : 6'd0;

		push_cmd.value = item.number[30:0];
		push_cmd.radix = item.radix;
		push_cmd.recip = RECIP_TABLE[table_idx];

		if (item.number == 32'sd0) begin
			push_cmd.kind = KIND_ZERO;
		end else if (item.number[31]) begin
			push_cmd.kind = KIND_EMPTY;
		end else if (!radix_ok) begin
			push_cmd.kind = KIND_BADBASE;
		end else begin
			push_cmd.kind = KIND_DIGITS;
		end
	end

endmodule

### rtl/rdc_back.sv
// ----------------------------------------------------------------------------
// Radix digit converter back
// Divides by the radix one digit at a time through a reciprocal multiply,
// stacks the remainders and pops them out as ASCII characters.
// ----------------------------------------------------------------------------
module rdc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  rdc_pkg::cmd_t    head,
	input  logic             queue_empty,
	output logic             pop,
	output rdc_pkg::result_t result,
	output logic             result_valid,
	input  logic             result_ready
);

	import rdc_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_REM  = 3'd2;
	localparam logic [2:0] S_READ = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0]       state_q;
	logic [30:0]      quot_q;
	logic [5:0]       radix_q;
	logic [31:0]      recip_q;
	logic [CNT_W-1:0] cnt_q;
	logic [62:0]      prod_s1;
	result_t          result_q;
	logic             result_valid_q;

	logic             out_free;
	logic             load_result;
	result_t          next_result;
	logic [30:0]      q_est;
	logic [36:0]      q_times_b;
	logic [30:0]      diff;
	logic [6:0]       rem_raw;
	logic [5:0]       rem;
	logic [30:0]      q_new;
	logic             stack_we;
	logic             stack_re;
	logic [5:0]       stack_rdata;

	assign out_free = !result_valid_q || result_ready;

	// Remainder correction: the estimate is low by at most one.
	always_comb begin
		q_est     = prod_s1[62:32];
		q_times_b = 37'(q_est) * 37'(radix_q);
		diff      = quot_q - q_times_b[30:0];
		rem_raw   = diff[6:0];
		if (rem_raw >= {1'b0, radix_q}) begin
			rem   = 6'(rem_raw - {1'b0, radix_q});
			q_new = q_est + 31'd1;
		end else begin
			rem   = rem_raw[5:0];
			q_new = q_est;
		end
	end

	// Queue pop, result load and stack control.
	always_comb begin
		pop         = 1'b0;
		load_result = 1'b0;
		next_result = '0;
		stack_we    = (state_q == S_REM) && (cnt_q < CNT_W'(MAX_DIGITS));
		stack_re    = (state_q == S_READ);
		case (state_q)
			S_IDLE: begin
				if (!queue_empty) begin
					case (head.kind)
						KIND_DIGITS: begin
							pop = 1'b1;
						end
						KIND_ZERO: begin
							pop              = out_free;
							load_result      = out_free;
							next_result      = '{digit_char: CHAR_ZERO, status: ST_OK, last: 1'b1};
						end
						KIND_EMPTY: begin
							pop              = out_free;
							load_result      = out_free;
							next_result      = '{digit_char: 7'd0, status: ST_EMPTY, last: 1'b1};
						end
						default: begin
							pop              = out_free;
							load_result      = out_free;
							next_result      = '{digit_char: 7'd0, status: ST_BADBASE, last: 1'b1};
						end
					endcase
				end
			end
			S_EMIT: begin
				load_result = out_free;
				next_result = '{digit_char: to_ascii(stack_rdata), status: ST_OK,
					last: (cnt_q == '0)};
			end
			default: begin
			end
		endcase
	end

	// Sequencer for the divide and pop loops.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (pop && head.kind == KIND_DIGITS) begin
						cnt_q   <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_REM;
				end
				S_REM: begin
					if (stack_we) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					state_q <= (q_new == 31'd0) ? S_READ : S_MUL;
				end
				S_READ: begin
					cnt_q   <= cnt_q - CNT_W'(1);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= (cnt_q == '0) ? S_IDLE : S_READ;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working operands and the registered reciprocal product.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && pop) begin
			quot_q  <= head.value;
			radix_q <= head.radix;
			recip_q <= head.recip;
		end else if (state_q == S_REM) begin
			quot_q <= q_new;
		end
		if (state_q == S_MUL) begin
			prod_s1 <= 63'(quot_q) * 63'(recip_q);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_result) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			result_q <= next_result;
		end
	end

	// Digit stack.
	rdc_ram #(
		.WIDTH(6),
		.DEPTH(MAX_DIGITS)
	) u_stack (
		.clk  (clk),
		.we   (stack_we),
		.waddr(cnt_q[STACK_AW-1:0]),
		.wdata(rem),
		.re   (stack_re),
		.raddr(STACK_AW'(cnt_q - CNT_W'(1))),
		.rdata(stack_rdata)
	);

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule
